// ===== src/gnss_binary_frame_encoder_core_defines.svh =====
// Assertion macros used by the back end of the frame encoder RTL.
`ifndef GNSS_BINARY_FRAME_ENCODER_CORE_DEFINES_SVH
`define GNSS_BINARY_FRAME_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GBFE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("gbfe assertion failed");
`define GBFE_ASSERT_NEVER(lbl, clk, rstn, cond) \
    `GBFE_ASSERT(lbl, clk, rstn, !(cond))
`else
`define GBFE_ASSERT(lbl, clk, rstn, prop)
`define GBFE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== src/gbfe_pkg.sv =====
// Package with payload types, command type, phase encoding and constants of the frame encoder.
`default_nettype none

package gbfe_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic       ACT_START   = 1'b0;
    localparam logic       ACT_PAYLOAD = 1'b1;
    localparam int         CMD_FIFO_DEPTH = 4;

    typedef struct packed {
        logic        action;
        logic [7:0]  class_byte;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_t;

    typedef struct packed {
        logic        is_start;
        logic        last;
        logic [7:0]  class_byte;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } cmd_t;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LENLO,
        PH_LENHI,
        PH_DATA,
        PH_CKA,
        PH_CKB
    } phase_t;

endpackage

`default_nettype wire

// ===== src/gbfe_front.sv =====
// Front end: accepts input transactions, tracks the open frame and issues commands.
`default_nettype none

module gbfe_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gbfe_pkg::in_t s_data,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output gbfe_pkg::cmd_t     cmd_data
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic        accept;
    logic        is_start;
    logic        payload_last;

    assign s_ready      = cmd_ready;
    assign accept       = s_valid && cmd_ready;
    assign is_start     = (s_data.action == gbfe_pkg::ACT_START);
    assign payload_last = (bytes_left_reg == 16'd1);

    always_comb begin
        cmd_valid                = s_valid && (is_start || frame_open_reg);
        cmd_data.is_start        = is_start;
        cmd_data.last            = is_start ? (s_data.payload_length == 16'd0) : payload_last;
        cmd_data.class_byte      = s_data.class_byte;
        cmd_data.msg_id          = s_data.msg_id;
        cmd_data.payload_length  = s_data.payload_length;
        cmd_data.data_byte       = s_data.data_byte;

        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        if (accept) begin
            if (is_start) begin
                frame_open_next = (s_data.payload_length != 16'd0);
                bytes_left_next = s_data.payload_length;
            end else if (frame_open_reg) begin
                frame_open_next = !payload_last;
                bytes_left_next = bytes_left_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
        end else begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/gbfe_fifo.sv =====
// Small register queue that carries commands from the front end to the back end.
`default_nettype none

module gbfe_fifo #(
    parameter int DEPTH = gbfe_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire gbfe_pkg::cmd_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output gbfe_pkg::cmd_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gbfe_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10: begin
                count_next = count_reg + 1'b1;
            end
            2'b01: begin
                count_next = count_reg - 1'b1;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/gbfe_back.sv =====
// Back end: sequences frame bytes, keeps the Fletcher sums and holds the output register.
`default_nettype none
`include "gnss_binary_frame_encoder_core_defines.svh"

module gbfe_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire gbfe_pkg::cmd_t cmd_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output gbfe_pkg::out_t      m_data
);

    gbfe_pkg::cmd_t   cmd_reg;
    gbfe_pkg::cmd_t   cmd_next;
    gbfe_pkg::phase_t phase_reg;
    gbfe_pkg::phase_t phase_next;
    logic             busy_reg;
    logic             busy_next;
    logic [7:0]       sum_a_reg;
    logic [7:0]       sum_a_next;
    logic [7:0]       sum_b_reg;
    logic [7:0]       sum_b_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    gbfe_pkg::out_t   m_data_reg;
    gbfe_pkg::out_t   m_data_next;
    logic             advance;
    logic             final_byte;
    logic             take_cmd;
    logic [7:0]       cur_byte;
    logic             summed;
    logic             ckb_out;
    logic             sync_out;
    logic             in_cka;
    logic             in_data;

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign cmd_ready = !busy_reg || (advance && final_byte);
    assign take_cmd  = cmd_valid && cmd_ready;
    assign ckb_out   = advance && (phase_reg == gbfe_pkg::PH_CKB);
    assign sync_out  = advance && (phase_reg == gbfe_pkg::PH_SYNC1);
    assign in_cka    = busy_reg && (phase_reg == gbfe_pkg::PH_CKA);
    assign in_data   = busy_reg && (phase_reg == gbfe_pkg::PH_DATA);

    always_comb begin
        final_byte = 1'b0;
        summed     = 1'b0;
        cur_byte   = 8'd0;
        case (phase_reg)
            gbfe_pkg::PH_SYNC1: begin
                cur_byte = gbfe_pkg::SYNC_FIRST;
            end
            gbfe_pkg::PH_SYNC2: begin
                cur_byte = gbfe_pkg::SYNC_SECOND;
            end
            gbfe_pkg::PH_CLASS: begin
                cur_byte = cmd_reg.class_byte;
                summed   = 1'b1;
            end
            gbfe_pkg::PH_ID: begin
                cur_byte = cmd_reg.msg_id;
                summed   = 1'b1;
            end
            gbfe_pkg::PH_LENLO: begin
                cur_byte = cmd_reg.payload_length[7:0];
                summed   = 1'b1;
            end
            gbfe_pkg::PH_LENHI: begin
                cur_byte   = cmd_reg.payload_length[15:8];
                summed     = 1'b1;
                final_byte = !cmd_reg.last;
            end
            gbfe_pkg::PH_DATA: begin
                cur_byte   = cmd_reg.data_byte;
                summed     = 1'b1;
                final_byte = !cmd_reg.last;
            end
            gbfe_pkg::PH_CKA: begin
                cur_byte = sum_a_reg;
            end
            gbfe_pkg::PH_CKB: begin
                cur_byte   = sum_b_reg;
                final_byte = 1'b1;
            end
            default: begin
                cur_byte = 8'd0;
            end
        endcase
    end

    always_comb begin
        cmd_next     = cmd_reg;
        phase_next   = phase_reg;
        busy_next    = busy_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (advance) begin
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = cur_byte;
            m_data_next.frame_end = (phase_reg == gbfe_pkg::PH_CKB);
            if (phase_reg == gbfe_pkg::PH_SYNC1) begin
                sum_a_next = 8'd0;
                sum_b_next = 8'd0;
            end else if (summed) begin
                sum_a_next = sum_a_reg + cur_byte;
                sum_b_next = sum_b_reg + sum_a_next;
            end
            if (final_byte) begin
                busy_next = 1'b0;
            end
            case (phase_reg)
                gbfe_pkg::PH_SYNC1: begin
                    phase_next = gbfe_pkg::PH_SYNC2;
                end
                gbfe_pkg::PH_SYNC2: begin
                    phase_next = gbfe_pkg::PH_CLASS;
                end
                gbfe_pkg::PH_CLASS: begin
                    phase_next = gbfe_pkg::PH_ID;
                end
                gbfe_pkg::PH_ID: begin
                    phase_next = gbfe_pkg::PH_LENLO;
                end
                gbfe_pkg::PH_LENLO: begin
                    phase_next = gbfe_pkg::PH_LENHI;
                end
                gbfe_pkg::PH_LENHI: begin
                    phase_next = gbfe_pkg::PH_CKA;
                end
                gbfe_pkg::PH_DATA: begin
                    phase_next = gbfe_pkg::PH_CKA;
                end
                gbfe_pkg::PH_CKA: begin
                    phase_next = gbfe_pkg::PH_CKB;
                end
                default: begin
                    phase_next = gbfe_pkg::PH_SYNC1;
                end
            endcase
        end

        if (take_cmd) begin
            cmd_next   = cmd_data;
            busy_next  = 1'b1;
            phase_next = cmd_data.is_start ? gbfe_pkg::PH_SYNC1 : gbfe_pkg::PH_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= gbfe_pkg::PH_SYNC1;
            busy_reg    <= 1'b0;
            sum_a_reg   <= 8'd0;
            sum_b_reg   <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            busy_reg    <= busy_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    `GBFE_ASSERT(a_ckb_ends_frame, aclk, aresetn, ckb_out |=> (m_valid && m_data.frame_end))
    `GBFE_ASSERT(a_cka_only_on_last, aclk, aresetn, in_cka |-> cmd_reg.last)
    `GBFE_ASSERT(a_sync_clears_sums, aclk, aresetn, sync_out |=> ({sum_a_reg, sum_b_reg} == '0))
    `GBFE_ASSERT_NEVER(a_data_not_start, aclk, aresetn, in_data && cmd_reg.is_start)

endmodule

`default_nettype wire

// ===== src/gnss_binary_frame_encoder_core.sv =====
// Top level of the binary frame encoder with 8-bit Fletcher checksum.
//
//   Port group   Direction  Payload type      Handshake
//   s_*          in         gbfe_pkg::in_t    s_valid / s_ready
//   m_*          out        gbfe_pkg::out_t   m_valid / m_ready
//
// The byte sequencer emits one frame byte per cycle unless m_ready or an empty queue stalls.
// A start emits 6 bytes, or 8 with zero length; a payload byte emits 1, or 3 when last.
// An accepted input passes the queue, then the back end's command and output registers.
// Reset is synchronous and active low; it empties the queue and closes any frame.
// A stall on m_ready fills the command queue, after which s_ready drops.
`default_nettype none

module gnss_binary_frame_encoder_core #(
    parameter int CMD_DEPTH = gbfe_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gbfe_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output gbfe_pkg::out_t     m_data
);

    logic           fq_in_valid;
    logic           fq_in_ready;
    gbfe_pkg::cmd_t fq_in_data;
    logic           fq_out_valid;
    logic           fq_out_ready;
    gbfe_pkg::cmd_t fq_out_data;

    gbfe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_in_valid),
        .cmd_ready (fq_in_ready),
        .cmd_data  (fq_in_data)
    );

    gbfe_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_in_valid),
        .push_ready (fq_in_ready),
        .push_data  (fq_in_data),
        .pop_valid  (fq_out_valid),
        .pop_ready  (fq_out_ready),
        .pop_data   (fq_out_data)
    );

    gbfe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fq_out_valid),
        .cmd_ready (fq_out_ready),
        .cmd_data  (fq_out_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
